### hw/rtl/gap_bp_pkg.sv
package gap_bp_pkg;

   localparam int ADDR_BITS = 12;
   localparam int HIST_BITS = 8;
   localparam int IDX_BITS = ADDR_BITS + HIST_BITS;

   // Counters are packed several to a memory row so that the clearing pass is short.
   localparam int ROW_SEL_BITS = (IDX_BITS > 3) ? 3 : 1;
   localparam int ROW_CTRS = 1 << ROW_SEL_BITS;
   localparam int ROW_BITS = 2 * ROW_CTRS;
   localparam int ROW_IDX_BITS = IDX_BITS - ROW_SEL_BITS;
   localparam int ROWS = 1 << ROW_IDX_BITS;

   localparam logic [1:0] CTR_STRONG_TAKEN = 2'b11;
   localparam logic [1:0] CTR_WEAK_TAKEN = 2'b10;
   localparam logic [1:0] CTR_STRONG_NOT_TAKEN = 2'b00;
   localparam logic [ROW_BITS-1:0] CLEAR_ROW = {ROW_CTRS{CTR_STRONG_TAKEN}};

   typedef struct packed {
      logic [31:0] branch_addr;
      logic taken;
   } req_type;

   typedef struct packed {
      logic predict_taken;
      logic pred_correct;
   } rsp_type;

endpackage

### hw/rtl/gap_two_level_branch_predictor.sv
// GAp two-level branch predictor. Each request transaction is one resolved branch
// (address and outcome); each yields exactly one response transaction carrying the
// prediction made before the update and whether it was correct. The pattern table
// of 2-bit counters lives in a single-port-write synchronous memory, eight counters
// to a row, read at request acceptance and written back in the following cycle,
// with the last written row forwarded to the next transaction. After reset the
// block writes all ROWS rows (131072 at the default sizes) to strongly taken and
// holds req_stall high meanwhile. After that it accepts one transaction per cycle
// unless a full response queue stalls it; each response passes the s1 stage and
// a two-entry response queue, which lets requests keep flowing while one waits.
module gap_two_level_branch_predictor (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  gap_bp_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output gap_bp_pkg::rsp_type rsp_data
);
   import gap_bp_pkg::*;

   logic [ROW_BITS-1:0] mem [ROWS];

   logic [HIST_BITS-1:0] hist_ff, hist_in;
   logic clr_active_ff, clr_active_in;
   logic [ROW_IDX_BITS-1:0] clr_addr_ff, clr_addr_in;

   logic s1_vld_ff, s1_vld_in;
   logic [ROW_IDX_BITS-1:0] s1_row_ff;
   logic [ROW_SEL_BITS-1:0] s1_sel_ff;
   logic s1_taken_ff;
   logic [ROW_BITS-1:0] rd_row_ff;

   logic fwd_vld_ff, fwd_vld_in;
   logic [ROW_IDX_BITS-1:0] fwd_addr_ff;
   logic [ROW_BITS-1:0] fwd_data_ff;

   rsp_type q_ff [2];
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] occ_ff, occ_in;

   logic accept, pop;
   logic [IDX_BITS-1:0] req_idx;
   logic [ROW_IDX_BITS-1:0] req_row;
   logic [ROW_BITS-1:0] cur_row, new_row;
   logic [1:0] ctr, ctr_new;
   logic pred;
   rsp_type s1_rsp;
   logic mem_we;
   logic [ROW_IDX_BITS-1:0] mem_waddr;
   logic [ROW_BITS-1:0] mem_wdata;

   assign pop = rsp_valid && !rsp_stall;
   assign req_stall = clr_active_ff
      || ((({1'b0, occ_ff} + {2'b00, s1_vld_ff}) == 3'd2) && !pop);
   assign accept = req_valid && !req_stall;

   assign req_idx = {req_data.branch_addr[ADDR_BITS-1:0], hist_ff};
   assign req_row = req_idx[IDX_BITS-1:ROW_SEL_BITS];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= mem[req_row];
   end

   // The row written at the previous edge is not yet in the registered read data.
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_row_ff)) begin
         cur_row = fwd_data_ff;
      end else begin
         cur_row = rd_row_ff;
      end
      ctr = cur_row[2*s1_sel_ff +: 2];
      pred = (ctr >= CTR_WEAK_TAKEN);
      if (s1_taken_ff) begin
         ctr_new = (ctr == CTR_STRONG_TAKEN) ? ctr : ctr + 2'd1;
      end else begin
         ctr_new = (ctr == CTR_STRONG_NOT_TAKEN) ? ctr : ctr - 2'd1;
      end
      for (int i = 0; i < ROW_CTRS; i++) begin
         if (s1_sel_ff == ROW_SEL_BITS'(i)) begin
            new_row[2*i +: 2] = ctr_new;
         end else begin
            new_row[2*i +: 2] = cur_row[2*i +: 2];
         end
      end
      s1_rsp.predict_taken = pred;
      s1_rsp.pred_correct = (pred == s1_taken_ff);
   end

   always_comb begin
      mem_we = clr_active_ff || s1_vld_ff;
      if (clr_active_ff) begin
         mem_waddr = clr_addr_ff;
         mem_wdata = CLEAR_ROW;
      end else begin
         mem_waddr = s1_row_ff;
         mem_wdata = new_row;
      end
   end

   always_comb begin
      hist_in = accept ? {hist_ff[HIST_BITS-2:0], req_data.taken} : hist_ff;
      clr_active_in = clr_active_ff && (clr_addr_ff != {ROW_IDX_BITS{1'b1}});
      clr_addr_in = clr_active_ff ? clr_addr_ff + ROW_IDX_BITS'(1) : clr_addr_ff;
      s1_vld_in = accept;
      fwd_vld_in = s1_vld_ff;
      wr_ptr_in = s1_vld_ff ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      occ_in = occ_ff + {1'b0, s1_vld_ff} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= {HIST_BITS{1'b1}};
         clr_active_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         occ_ff <= 2'd0;
      end else begin
         hist_ff <= hist_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff <= clr_addr_in;
         s1_vld_ff <= s1_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff <= req_row;
         s1_sel_ff <= req_idx[ROW_SEL_BITS-1:0];
         s1_taken_ff <= req_data.taken;
      end
      fwd_addr_ff <= s1_row_ff;
      fwd_data_ff <= new_row;
      if (s1_vld_ff) begin
         q_ff[wr_ptr_ff] <= s1_rsp;
      end
   end

   assign rsp_valid = (occ_ff != 2'd0);
   assign rsp_data = q_ff[rd_ptr_ff];

endmodule

### tb/testbench.sv
module testbench;
   import gap_bp_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOT_BRANCHES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Expected prediction for every branch accepted but not yet answered.
   rsp_type pending_predictions[$];

   // Mirror of the predictor state.
   logic [HIST_BITS-1:0] branch_history;
   logic [1:0] pattern_ctr [0:(1 << IDX_BITS) - 1];

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int cycle_count = 0;
   int branches_sent = 0;
   int predictions_checked = 0;
   int mispredicts = 0;
   int mismatch_count = 0;

   gap_two_level_branch_predictor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Looks up the counter, forms the prediction, then trains the counter and
   // shifts the outcome into the history, as the hardware does per branch.
   function automatic rsp_type predict_and_train(input req_type br);
      logic [IDX_BITS-1:0] idx;
      logic [1:0] ctr;
      rsp_type outcome;
      idx = {br.branch_addr[ADDR_BITS-1:0], branch_history};
      ctr = pattern_ctr[idx];
      outcome.predict_taken = (ctr >= CTR_WEAK_TAKEN);
      outcome.pred_correct = (outcome.predict_taken == br.taken);
      if (br.taken) begin
         if (ctr != CTR_STRONG_TAKEN) ctr = ctr + 2'd1;
      end else begin
         if (ctr != CTR_STRONG_NOT_TAKEN) ctr = ctr - 2'd1;
      end
      pattern_ctr[idx] = ctr;
      branch_history = (branch_history << 1) | HIST_BITS'(br.taken);
      return outcome;
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is accepted.
   task automatic send_branch(input logic [31:0] addr, input logic tk);
      req_type br;
      rsp_type want;
      br.branch_addr = addr;
      br.taken = tk;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_data <= {$urandom, 1'($urandom_range(1))};
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= br;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_and_train(br);
      if (!want.pred_correct) mispredicts++;
      pending_predictions.push_back(want);
      branches_sent++;
   endtask

   // Receiver stall and response checking share one edge-triggered process.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_predictions.size() == 0) begin
            report_mismatch("response transaction with no branch outstanding");
         end else begin
            want = pending_predictions.pop_front();
            predictions_checked++;
            if (rsp_data.predict_taken !== want.predict_taken)
               report_mismatch($sformatf("predict_taken got %b want %b",
                                         rsp_data.predict_taken, want.predict_taken));
            if (rsp_data.pred_correct !== want.pred_correct)
               report_mismatch($sformatf("pred_correct got %b want %b",
                                         rsp_data.pred_correct, want.pred_correct));
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // History starts all ones, so repeated taken branches keep hitting one counter at 3.
   task automatic test_taken_saturation();
      repeat (3) send_branch(32'hFFFF_FFFF, 1'b1);
   endtask

   // Eight not-taken branches clear the history; the next ones walk one counter
   // down to 0 and hold it there. A taken branch then moves it up one step, and
   // the one after lands on another counter because the history has changed.
   task automatic test_not_taken_saturation();
      repeat (8) send_branch(32'h0000_0000, 1'b0);
      repeat (5) send_branch(32'h0000_0000, 1'b0);
      repeat (2) send_branch(32'h0000_0000, 1'b1);
   endtask

   task automatic test_upper_addr_ignored();
      logic [31:0] addr;
      addr = $urandom;
      addr[31:ADDR_BITS] = '1;
      send_branch(addr, 1'b1);
      addr[31:ADDR_BITS] = '0;
      send_branch(addr, 1'b0);
      addr[31:ADDR_BITS] = (32 - ADDR_BITS)'($urandom);
      send_branch(addr, 1'b1);
      addr[31] = ~addr[31];
      send_branch(addr, 1'b1);
   endtask

   // Most branches come from a few hot addresses with fixed biases or loop
   // patterns so the counters saturate and the history repeats; the rest are noise.
   task automatic test_random_traffic(input int n_items, input int send_pct,
                                      input int rcv_pct);
      logic [ADDR_BITS-1:0] hot_low [HOT_BRANCHES];
      int hot_bias [HOT_BRANCHES];
      int hot_period [HOT_BRANCHES];
      int hot_trips [HOT_BRANCHES];
      int k;
      logic [31:0] addr;
      logic tk;
      sender_idle_pct = send_pct;
      receiver_idle_pct = rcv_pct;
      for (int h = 0; h < HOT_BRANCHES; h++) begin
         hot_low[h] = ADDR_BITS'($urandom);
         hot_period[h] = $urandom_range(5);
         hot_trips[h] = 0;
         case ($urandom_range(4))
            0: hot_bias[h] = 0;
            1: hot_bias[h] = 5;
            2: hot_bias[h] = 50;
            3: hot_bias[h] = 95;
            default: hot_bias[h] = 100;
         endcase
      end
      for (int i = 0; i < n_items; i++) begin
         addr = $urandom;
         if ($urandom_range(99) < 80) begin
            k = $urandom_range(HOT_BRANCHES - 1);
            addr[ADDR_BITS-1:0] = hot_low[k];
            if (hot_period[k] != 0) begin
               hot_trips[k]++;
               tk = (hot_trips[k] % (hot_period[k] + 1)) != 0;
            end else begin
               tk = ($urandom_range(99) < hot_bias[k]);
            end
         end else begin
            tk = 1'($urandom_range(1));
         end
         send_branch(addr, tk);
      end
   endtask

   initial begin
      foreach (pattern_ctr[i]) pattern_ctr[i] = CTR_STRONG_TAKEN;
      branch_history = '1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 13;
      receiver_idle_pct = 64;
      test_taken_saturation();
      test_not_taken_saturation();
      test_upper_addr_ignored();
      test_random_traffic(643, 13, 64);
      test_random_traffic(643, 64, 13);
      test_random_traffic(643, 0, 0);

      req_valid <= 1'b0;
      while (pending_predictions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d branches (%0d mispredicted) and checked %0d predictions,",
               branches_sent, mispredicts, predictions_checked);
      $display("covering counter saturation, address aliasing and three idling mixes.");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
